// File: hdl/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle converter.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Condition in this cycle implies consequence in the same cycle.
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/qte_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler converter.
// No dependencies.
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CW = 38;        // CORDIC vector width, Q4.28 operands plus growth
  localparam int AW = 24;        // angle accumulator width, Q20 radians
  localparam int SQ_RW = 29;     // root width, result of sqrt in Q28
  localparam int SQ_REMW = 59;   // remainder width of the sqrt chain

  localparam logic signed [AW-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [14:0] HALF_PI_Q13 = 15'sd12868;
  localparam logic signed [CW-1:0] ONE_Q28 = CW'(64'sd1 <<< 28);
  localparam logic [13:0] POLE_THR_RESET = 14'd8176;

  localparam logic [1:0] POLE_NONE  = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  // Operands handed down the sqrt chain alongside the root.
  typedef struct packed {
    logic signed [CW-1:0] hy;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] s;
    logic [1:0]           pole;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    lane_t      h;
    lane_t      a;
    lane_t      b;
    logic [1:0] pole;
  } cord_t;

  function automatic logic signed [AW-1:0] atan_q20(input logic [4:0] i);
    logic signed [AW-1:0] r;
    case (i)
      5'd0:  r = 24'sd823550;
      5'd1:  r = 24'sd486170;
      5'd2:  r = 24'sd256879;
      5'd3:  r = 24'sd130396;
      5'd4:  r = 24'sd65451;
      5'd5:  r = 24'sd32757;
      5'd6:  r = 24'sd16383;
      5'd7:  r = 24'sd8192;
      5'd8:  r = 24'sd4096;
      5'd9:  r = 24'sd2048;
      5'd10: r = 24'sd1024;
      5'd11: r = 24'sd512;
      5'd12: r = 24'sd256;
      5'd13: r = 24'sd128;
      5'd14: r = 24'sd64;
      5'd15: r = 24'sd32;
      5'd16: r = 24'sd16;
      5'd17: r = 24'sd8;
      5'd18: r = 24'sd4;
      5'd19: r = 24'sd2;
      5'd20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Vectors in the left half plane are turned by a quarter turn first.
  function automatic lane_t prerot(input logic signed [CW-1:0] y,
                                   input logic signed [CW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        l.x = y;
        l.y = -x;
        l.z = HALF_PI_Q20;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -HALF_PI_Q20;
      end
    end
    return l;
  endfunction

  // Q20 to Q13 with rounding, arithmetic shift.
  function automatic logic signed [AW:0] q20_to_q13(input logic signed [AW:0] a);
    logic signed [AW:0] t;
    t = a + (AW+1)'(64);
    return t >>> 7;
  endfunction

endpackage

// File: hdl/qte_sqrt_cell.sv
// One bit of the floor square root; carries the item payload to the next cell.
// Depends on qte_pkg.
module qte_sqrt_cell
  import qte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         bit_idx,
  input  logic               valid_i,
  output logic               rdy_o,
  input  item_t              item_i,
  input  logic [SQ_REMW-1:0] rem_i,
  input  logic [SQ_RW-1:0]   root_i,
  output logic               valid_o,
  input  logic               rdy_i,
  output item_t              item_o,
  output logic [SQ_REMW-1:0] rem_o,
  output logic [SQ_RW-1:0]   root_o
);

  logic               valid_r;
  item_t              item_r;
  logic [SQ_REMW-1:0] rem_r;
  logic [SQ_RW-1:0]   root_r;
  logic [SQ_REMW-1:0] trial;
  logic [SQ_REMW-1:0] rem_nxt;
  logic [SQ_RW-1:0]   root_nxt;

  assign rdy_o = !valid_r || rdy_i;

  // Trial subtrahend is (2r + 2^k) * 2^k.
  always_comb begin
    trial = (SQ_REMW'(root_i) << (bit_idx + 5'd1)) + (SQ_REMW'(1) << {bit_idx, 1'b0});
    rem_nxt = rem_i;
    root_nxt = root_i;
    if (rem_i >= trial) begin
      rem_nxt = rem_i - trial;
      root_nxt = root_i | (SQ_RW'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && valid_i) begin
      item_r <= item_i;
      rem_r <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o = item_r;
  assign rem_o = rem_r;
  assign root_o = root_r;

endmodule

// File: hdl/qte_cordic_cell.sv
// One vectoring CORDIC iteration applied to the heading, attitude and bank lanes.
// Depends on qte_pkg.
module qte_cordic_cell
  import qte_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  [4:0] stage_idx,
  input  logic  valid_i,
  output logic  rdy_o,
  input  cord_t data_i,
  output logic  valid_o,
  input  logic  rdy_i,
  output cord_t data_o
);

  logic  valid_r;
  cord_t data_r;
  cord_t data_nxt;

  function automatic lane_t rotate(input lane_t l, input logic [4:0] k);
    lane_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = l.x >>> k;
    ys = l.y >>> k;
    r = l;
    if (!l.y[CW-1]) begin
      r.x = l.x + ys;
      r.y = l.y - xs;
      r.z = l.z + atan_q20(k);
    end else begin
      r.x = l.x - ys;
      r.y = l.y + xs;
      r.z = l.z - atan_q20(k);
    end
    return r;
  endfunction

  assign rdy_o = !valid_r || rdy_i;

  always_comb begin
    data_nxt = data_i;
    data_nxt.h = rotate(data_i.h, stage_idx);
    data_nxt.a = rotate(data_i.a, stage_idx);
    data_nxt.b = rotate(data_i.b, stage_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o = data_r;

endmodule

// File: hdl/quaternion_to_euler_angles.sv
// Channel   Handshake            Payload
// in_       in_valid/in_ready    in_quat_x, in_quat_y, in_quat_z, in_quat_w
// out_      out_valid/out_ready  out_bank_angle, out_heading_angle, out_attitude_angle,
//                                out_pole_case
// cfg_      cfg_wr_en            cfg_wr_data (pole threshold)
//
// The pipeline takes one item per cycle while the output is not stalled.
// The 29-cell square root chain and the CORDIC cell chain make up most of the pipeline.
// Every stage stalls only when the stage after it is full, so bubbles close up.
// Reset is synchronous, active low; it empties the pipeline and loads the threshold.
// Top level of the quaternion to Euler angle converter.
// Depends on qte_pkg, qte_sqrt_cell, qte_cordic_cell and the assertion header.
`include "quaternion_to_euler_angles_assert.svh"

module quaternion_to_euler_angles
  import qte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_bank_angle,
  output logic signed [16:0] out_heading_angle,
  output logic signed [14:0] out_attitude_angle,
  output logic [1:0]         out_pole_case,
  input  logic               cfg_wr_en,
  input  logic [13:0]        cfg_wr_data
);

  localparam int SQ_N = SQ_RW;

  logic [13:0] thr_r;

  // Stage 1: products.
  logic v1_r, rdy1;
  logic signed [31:0] p_xy_r, p_zw_r, p_xx_r, p_yy_r, p_zz_r;
  logic signed [31:0] p_xw_r, p_yw_r, p_xz_r, p_yz_r;
  logic signed [15:0] x1_r, w1_r;

  // Stage 2: pole test and CORDIC operands.
  logic v2_r, rdy2;
  item_t item2_r, item2_nxt;
  logic big2_r, big2_nxt;
  logic [27:0] mag2_r, mag2_nxt;

  // Stage 3: square of the sine term.
  logic v3_r, rdy3;
  item_t item3_r;
  logic big3_r;
  logic [55:0] sq3_r;

  // Stage 4: radicand.
  logic v4_r, rdy4;
  item_t item4_r;
  logic [SQ_REMW-1:0] rad4_r;

  logic               sq_v   [SQ_N+1];
  logic               sq_rdy [SQ_N+1];
  item_t              sq_item[SQ_N+1];
  logic [SQ_REMW-1:0] sq_rem [SQ_N+1];
  logic [SQ_RW-1:0]   sq_root[SQ_N+1];

  // Stage 5: quarter turn ahead of the CORDIC chain.
  logic v5_r, rdy5;
  cord_t cd5_r, cd5_nxt;

  logic  cd_v  [CORDIC_STAGES+1];
  logic  cd_rdy[CORDIC_STAGES+1];
  cord_t cd_d  [CORDIC_STAGES+1];

  logic out_valid_r, rdy_out;
  logic signed [15:0] bank_r, bank_nxt;
  logic signed [16:0] head_r, head_nxt;
  logic signed [14:0] att_r, att_nxt;
  logic [1:0] pole_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= POLE_THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p_xy_r <= in_quat_x * in_quat_y;
      p_zw_r <= in_quat_z * in_quat_w;
      p_xx_r <= in_quat_x * in_quat_x;
      p_yy_r <= in_quat_y * in_quat_y;
      p_zz_r <= in_quat_z * in_quat_z;
      p_xw_r <= in_quat_x * in_quat_w;
      p_yw_r <= in_quat_y * in_quat_w;
      p_xz_r <= in_quat_x * in_quat_z;
      p_yz_r <= in_quat_y * in_quat_z;
      x1_r <= in_quat_x;
      w1_r <= in_quat_w;
    end
  end

  always_comb begin
    logic signed [32:0] test;
    logic signed [32:0] lim;
    logic signed [CW-1:0] mag;
    test = 33'(p_xy_r) + 33'(p_zw_r);
    lim = $signed({5'b0, thr_r, 14'b0});
    item2_nxt.s = CW'(test) <<< 1;
    item2_nxt.hy = (CW'(p_yw_r) - CW'(p_xz_r)) <<< 1;
    item2_nxt.hx = ONE_Q28 - ((CW'(p_yy_r) + CW'(p_zz_r)) <<< 1);
    item2_nxt.by = (CW'(p_xw_r) - CW'(p_yz_r)) <<< 1;
    item2_nxt.bx = ONE_Q28 - ((CW'(p_xx_r) + CW'(p_zz_r)) <<< 1);
    item2_nxt.pole = POLE_NONE;
    if (test > lim) begin
      item2_nxt.pole = POLE_NORTH;
    end else if (test < -lim) begin
      item2_nxt.pole = POLE_SOUTH;
    end
    // At a pole the heading CORDIC works on the raw x and w components.
    if (item2_nxt.pole != POLE_NONE) begin
      item2_nxt.hy = CW'(x1_r);
      item2_nxt.hx = CW'(w1_r);
    end
    mag = item2_nxt.s[CW-1] ? -item2_nxt.s : item2_nxt.s;
    mag2_nxt = mag[27:0];
    big2_nxt = |mag[CW-1:28];
  end

  assign rdy2 = !v2_r || rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      item2_r <= item2_nxt;
      big2_r <= big2_nxt;
      mag2_r <= mag2_nxt;
    end
  end

  assign rdy3 = !v3_r || rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      item3_r <= item2_r;
      big3_r <= big2_r;
      sq3_r <= mag2_r * mag2_r;
    end
  end

  assign rdy4 = !v4_r || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  // A sine term of magnitude one or more leaves a zero cosine.
  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      item4_r <= item3_r;
      rad4_r <= big3_r ? '0 : (SQ_REMW'(1) << 56) - SQ_REMW'(sq3_r);
    end
  end

  assign sq_v[0] = v4_r;
  assign sq_item[0] = item4_r;
  assign sq_rem[0] = rad4_r;
  assign sq_root[0] = '0;
  assign sq_rdy[SQ_N] = rdy5;

  for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bit_idx (5'(SQ_N - 1 - g)),
      .valid_i (sq_v[g]),
      .rdy_o   (sq_rdy[g]),
      .item_i  (sq_item[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .valid_o (sq_v[g+1]),
      .rdy_i   (sq_rdy[g+1]),
      .item_o  (sq_item[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1])
    );
  end

  always_comb begin
    cd5_nxt.h = prerot(sq_item[SQ_N].hy, sq_item[SQ_N].hx);
    cd5_nxt.a = prerot(sq_item[SQ_N].s, CW'(sq_root[SQ_N]));
    cd5_nxt.b = prerot(sq_item[SQ_N].by, sq_item[SQ_N].bx);
    cd5_nxt.pole = sq_item[SQ_N].pole;
  end

  assign rdy5 = !v5_r || cd_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= sq_v[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && sq_v[SQ_N]) begin
      cd5_r <= cd5_nxt;
    end
  end

  assign cd_v[0] = v5_r;
  assign cd_d[0] = cd5_r;
  assign cd_rdy[CORDIC_STAGES] = rdy_out;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    qte_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (5'(g)),
      .valid_i   (cd_v[g]),
      .rdy_o     (cd_rdy[g]),
      .data_i    (cd_d[g]),
      .valid_o   (cd_v[g+1]),
      .rdy_i     (cd_rdy[g+1]),
      .data_o    (cd_d[g+1])
    );
  end

  always_comb begin
    cord_t d;
    logic signed [AW:0] zh, za, zb;
    logic signed [AW:0] hq, aq, bq;
    d = cd_d[CORDIC_STAGES];
    // The angle of a zero vector is zero.
    zh = d.h.zero ? '0 : (AW+1)'(d.h.z);
    za = d.a.zero ? '0 : (AW+1)'(d.a.z);
    zb = d.b.zero ? '0 : (AW+1)'(d.b.z);
    aq = q20_to_q13(za);
    bq = q20_to_q13(zb);
    hq = q20_to_q13(zh);
    head_nxt = hq[16:0];
    att_nxt = aq[14:0];
    bank_nxt = bq[15:0];
    case (d.pole)
      POLE_NORTH: begin
        hq = q20_to_q13(zh <<< 1);
        head_nxt = hq[16:0];
        att_nxt = HALF_PI_Q13;
        bank_nxt = '0;
      end
      POLE_SOUTH: begin
        hq = q20_to_q13(-(zh <<< 1));
        head_nxt = hq[16:0];
        att_nxt = -HALF_PI_Q13;
        bank_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign rdy_out = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= cd_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && cd_v[CORDIC_STAGES]) begin
      bank_r <= bank_nxt;
      head_r <= head_nxt;
      att_r <= att_nxt;
      pole_r <= cd_d[CORDIC_STAGES].pole;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bank_angle = bank_r;
  assign out_heading_angle = head_r;
  assign out_attitude_angle = att_r;
  assign out_pole_case = pole_r;

  `QTE_ASSERT_NOW(a_pole_bank_zero, out_valid && (out_pole_case != POLE_NONE), out_bank_angle == '0, "bank angle not zero at a pole")
  `QTE_ASSERT_NOW(a_north_attitude, out_valid && (out_pole_case == POLE_NORTH), out_attitude_angle == HALF_PI_Q13, "north pole attitude wrong")
  `QTE_ASSERT_NOW(a_front_ready, !v1_r, in_ready, "input stalled with empty first stage")
  `QTE_ASSERT_NEXT(a_out_fill, !out_valid && cd_v[CORDIC_STAGES], out_valid, "finished item not moved to output")

endmodule

// File: tb/quaternion_to_euler_angles_tb.sv
// Self-checking testbench for the quaternion to Euler angle converter.
// Needs qte_pkg and the quaternion_to_euler_angles top level, nothing else.
module quaternion_to_euler_angles_tb;
  import qte_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS = 110;
  localparam int NUM_PHASES = 8;

  localparam longint ATAN_TAB [0:23] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic signed [15:0] bank;
    logic signed [16:0] heading;
    logic signed [14:0] attitude;
    logic [1:0]         pole;
  } euler_t;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    bit                 known;
    logic [1:0]         pole;
    logic signed [14:0] attitude;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_quat_x = '0, in_quat_y = '0, in_quat_z = '0, in_quat_w = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic signed [15:0] out_bank_angle;
  logic signed [16:0] out_heading_angle;
  logic signed [14:0] out_attitude_angle;
  logic [1:0] out_pole_case;
  logic cfg_wr_en = 1'b0;
  logic [13:0] cfg_wr_data = '0;

  euler_t euler_q[$];
  logic [13:0] threshold = POLE_THR_RESET;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int poles_seen = 0;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  quaternion_to_euler_angles i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z), .in_quat_w(in_quat_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_bank_angle(out_bank_angle), .out_heading_angle(out_heading_angle),
    .out_attitude_angle(out_attitude_angle), .out_pole_case(out_pole_case),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Vectoring CORDIC, angle in Q20; left half plane vectors get a quarter turn first.
  function automatic longint cordic_angle(input longint yv, input longint xv);
    longint xa, ya, za, xs, ys, t;
    xa = xv;
    ya = yv;
    za = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xa < 0) begin
      if (ya >= 0) begin
        t = xa; xa = ya; ya = -t; za = longint'(HALF_PI_Q20);
      end else begin
        t = xa; xa = -ya; ya = t; za = -longint'(HALF_PI_Q20);
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      xs = xa >>> i;
      ys = ya >>> i;
      if (ya >= 0) begin
        xa = xa + ys; ya = ya - xs; za = za + ATAN_TAB[i];
      end else begin
        xa = xa - ys; ya = ya + xs; za = za - ATAN_TAB[i];
      end
    end
    return za;
  endfunction

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint to_q13(input longint a);
    return (a + 64) >>> 7;
  endfunction

  function automatic euler_t predict_euler(input logic signed [15:0] qx, qy, qz, qw,
                                           input logic [13:0] thr);
    longint x, y, z, w, tst, lim, s, c, hd, at, bk;
    longint unsigned mag, sq;
    euler_t r;
    x = longint'(qx); y = longint'(qy); z = longint'(qz); w = longint'(qw);
    tst = x * y + z * w;
    lim = longint'({50'd0, thr}) << 14;
    bk = 0;
    r.pole = POLE_NONE;
    if (tst > lim) begin
      hd = to_q13(2 * cordic_angle(x, w));
      at = longint'(HALF_PI_Q13);
      r.pole = POLE_NORTH;
    end else if (tst < -lim) begin
      hd = to_q13(-2 * cordic_angle(x, w));
      at = -longint'(HALF_PI_Q13);
      r.pole = POLE_SOUTH;
    end else begin
      s = 2 * tst;
      mag = (s < 0) ? -s : s;
      sq = mag * mag;
      c = 0;
      if (sq < (64'd1 << 56)) c = floor_sqrt((64'd1 << 56) - sq);
      hd = to_q13(cordic_angle(2*y*w - 2*x*z, (64'sd1 << 28) - 2*y*y - 2*z*z));
      at = to_q13(cordic_angle(s, c));
      bk = to_q13(cordic_angle(2*x*w - 2*y*z, (64'sd1 << 28) - 2*x*x - 2*z*z));
    end
    r.bank = bk[15:0];
    r.heading = hd[16:0];
    r.attitude = at[14:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", field, got, want,
             results_checked);
    errors++;
  endtask

  always @(posedge clk) begin
    euler_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (euler_q.size() == 0) begin
          report_mismatch("unexpected result", out_pole_case, -1);
        end else begin
          e = euler_q.pop_front();
          if (out_bank_angle !== e.bank) report_mismatch("bank", out_bank_angle, e.bank);
          if (out_heading_angle !== e.heading)
            report_mismatch("heading", out_heading_angle, e.heading);
          if (out_attitude_angle !== e.attitude)
            report_mismatch("attitude", out_attitude_angle, e.attitude);
          if (out_pole_case !== e.pole) report_mismatch("pole", out_pole_case, e.pole);
          if (e.pole != POLE_NONE) poles_seen++;
        end
        results_checked++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("quaternion_to_euler_angles_tb failed");
        $finish;
      end
    end
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Holds the item until accepted; the expectation is queued at acceptance.
  task automatic send_quat(input logic signed [15:0] qx, qy, qz, qw,
                           input bit known, input logic [1:0] pole,
                           input logic signed [14:0] att);
    euler_t e;
    in_valid <= 1'b1;
    in_quat_x <= qx; in_quat_y <= qy; in_quat_z <= qz; in_quat_w <= qw;
    do @(posedge clk); while (!in_ready);
    e = predict_euler(qx, qy, qz, qw, threshold);
    if (known) begin
      e.pole = pole;
      e.attitude = att;
      e.bank = '0;
    end
    euler_q.push_back(e);
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (euler_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_quat();
    real a, b, c, d, n;
    logic signed [15:0] qx, qy, qz, qw;
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      a = real'($urandom_range(65535)) - 32768.0;
      b = real'($urandom_range(65535)) - 32768.0;
      c = real'($urandom_range(65535)) - 32768.0;
      d = real'($urandom_range(65535)) - 32768.0;
      n = $sqrt(a*a + b*b + c*c + d*d);
      if (n < 1.0) begin
        a = 0.0; b = 0.0; c = 0.0; d = 1.0; n = 1.0;
      end
      qx = 16'($rtoi(a / n * 16384.0)); qy = 16'($rtoi(b / n * 16384.0));
      qz = 16'($rtoi(c / n * 16384.0)); qw = 16'($rtoi(d / n * 16384.0));
    end else if (kind < 80) begin
      // Close to a pole, where the threshold compare decides.
      qx = 16'(11585 + $urandom_range(80) - 40);
      qy = 16'(11585 + $urandom_range(80) - 40);
      if ($urandom_range(1)) qy = -qy;
      if ($urandom_range(1)) qx = -qx;
      qz = 16'($urandom_range(600) - 300);
      qw = 16'($urandom_range(600) - 300);
    end else begin
      qx = 16'($urandom); qy = 16'($urandom); qz = 16'($urandom); qw = 16'($urandom);
    end
    send_quat(qx, qy, qz, qw, 1'b0, POLE_NONE, '0);
  endtask

  initial begin
    dir_row_t rows[21];
    logic [13:0] thr_list[NUM_PHASES];
    rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 1'b1, POLE_NORTH, HALF_PI_Q13},
      '{16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 1'b1, POLE_NORTH, HALF_PI_Q13},
      '{16'sd11585, 16'sd11585, 16'sd0, -16'sd5, 1'b1, POLE_NORTH, HALF_PI_Q13},
      '{16'sd11585, -16'sd11585, 16'sd0, 16'sd0, 1'b1, POLE_SOUTH, -HALF_PI_Q13},
      '{16'sd0, 16'sd0, -16'sd11585, 16'sd11585, 1'b1, POLE_SOUTH, -HALF_PI_Q13},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, POLE_NORTH, HALF_PI_Q13},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, POLE_NORTH, HALF_PI_Q13},
      '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1, POLE_SOUTH, -HALF_PI_Q13},
      '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd0, 1'b1, POLE_SOUTH, -HALF_PI_Q13},
      '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b1, POLE_NORTH, HALF_PI_Q13},
      '{16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192, 1'b0, POLE_NONE, 15'sd0},
      '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd11500, 16'sd11500, 16'sd0, 16'sd1000, 1'b0, POLE_NONE, 15'sd0},
      '{16'sd4096, -16'sd12000, 16'sd3000, 16'sd9000, 1'b0, POLE_NONE, 15'sd0}
    };
    thr_list = '{14'd0, 14'd8192, 14'd16383, 14'd8176, 14'd1, 14'd8190, 14'd4096,
                 14'd0};
    thr_list[NUM_PHASES-1] = 14'($urandom_range(16383));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i])
      send_quat(rows[i].qx, rows[i].qy, rows[i].qz, rows[i].qw, rows[i].known,
                rows[i].pole, rows[i].attitude);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= thr_list[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      threshold = thr_list[p];
      case (p % 4)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 48; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Halfway through, hold off until the pipeline has emptied.
        if (k == PHASE_ITEMS / 2) wait_drained();
        random_quat();
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d quaternions over %0d threshold settings; checked %0d results.",
             items_sent, NUM_PHASES + 1, results_checked);
    $display("%0d results were pole cases; %0d mismatches.", poles_seen, errors);
    if (errors == 0) begin
      $display("quaternion_to_euler_angles_tb passed");
    end else begin
      $display("quaternion_to_euler_angles_tb failed");
    end
    $finish;
  end

endmodule
